[src/jml_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and stage records of the JPEG MCU layout calculator.
package jml_pkg;

    // Largest frame component count; larger counts saturate to it.
    localparam int COMP_N      = 4;
    // Largest MCU block count accepted and recorded.
    localparam int MCU_BLK_MAX = 10;

    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 3;
    localparam int ID_W    = 2;
    localparam int CODES_W = 8;
    localparam int CODE_N  = CODES_W / ID_W;
    localparam int SCAN_N  = CODES_W / ID_W;
    localparam int FAC_W   = 3;
    localparam int BLK_W   = 14;
    localparam int NBLK_W  = 7;
    localparam int MAP_W   = 20;
    localparam int MAP_SLOTS = MAP_W / ID_W;
    localparam int MAP_REC = (MCU_BLK_MAX < MAP_SLOTS) ? MCU_BLK_MAX : MAP_SLOTS;
    localparam int CFG_W   = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // Ceiling-division numerators: size * factor + (max - 1) fits in 18 bits.
    localparam int NUM_W       = 18;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP3 = 17'd87381;   // floor(2^18 / 3)
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam int LANE_N = 4;
    typedef enum logic [1:0] {
        LANE_HORIZ,
        LANE_VERT,
        LANE_ROW,
        LANE_COL
    } t_lane;

    typedef logic [FAC_W-1:0] t_fac;

    // Decoded frame and scan header.
    typedef struct packed {
        logic [SIZE_W-1:0]                 width;
        logic [SIZE_W-1:0]                 height;
        logic [CNT_W-1:0]                  nf;
        t_fac [CODE_N-1:0]                 hf;
        t_fac [CODE_N-1:0]                 vf;
        t_fac                              hmax;
        t_fac                              vmax;
        logic                              single;
        logic [ID_W-1:0]                   first;
        logic [SCAN_N-1:0][ID_W-1:0]       ids;
        logic [SCAN_N-1:0][NBLK_W-1:0]     pfx;
    } t_hdr;

    // One component's worth of division work.
    typedef struct packed {
        logic [ID_W-1:0]                   comp;
        logic                              last;
        logic [LANE_N-1:0][NUM_W-1:0]      num;
        t_fac [LANE_N-1:0]                 den;
        logic [LANE_N-1:0]                 to_blocks;
        logic [NBLK_W-1:0]                 nblk;
        logic [MAP_W-1:0]                  map;
        logic                              ok;
    } t_slot;

endpackage

[src/jml_if.sv]
`timescale 1ns / 1ps
// Header and result channel interfaces of the JPEG MCU layout calculator.
interface jml_in_if import jml_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SIZE_W-1:0]      image_width;
    logic [SIZE_W-1:0]      image_height;
    logic [CNT_W-1:0]       frame_components;
    logic [CODES_W-1:0]     h_factor_codes;
    logic [CODES_W-1:0]     v_factor_codes;
    logic [CNT_W-1:0]       scan_components;
    logic [CODES_W-1:0]     scan_list;
    logic [ID_W-1:0]        first_component;

    modport source (
        output valid, image_width, image_height, frame_components, h_factor_codes,
               v_factor_codes, scan_components, scan_list, first_component,
        input  ready
    );
    modport sink (
        input  valid, image_width, image_height, frame_components, h_factor_codes,
               v_factor_codes, scan_components, scan_list, first_component,
        output ready
    );
endinterface

interface jml_out_if import jml_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ID_W-1:0]        comp_index;
    logic [BLK_W-1:0]       horiz_blocks;
    logic [BLK_W-1:0]       vert_blocks;
    logic [BLK_W-1:0]       mcus_per_row;
    logic [BLK_W-1:0]       mcus_per_col;
    logic [NBLK_W-1:0]      blocks_per_mcu;
    logic [MAP_W-1:0]       mcu_origin_map;
    logic                   layout_valid;
    logic                   last;

    modport source (
        output valid, comp_index, horiz_blocks, vert_blocks, mcus_per_row, mcus_per_col,
               blocks_per_mcu, mcu_origin_map, layout_valid, last,
        input  ready
    );
    modport sink (
        input  valid, comp_index, horiz_blocks, vert_blocks, mcus_per_row, mcus_per_col,
               blocks_per_mcu, mcu_origin_map, layout_valid, last,
        output ready
    );
endinterface

[src/jpeg_mcu_layout_calc.sv]
`timescale 1ns / 1ps
// A header's first result passes the decode register, the sequencer's header and slot
// registers and the divider's estimate and output registers; further components follow.
// Throughput: one result per cycle while the output is ready; the component sequencer
// issues min(frame_components, 4) slots per header and takes the next as it issues the last.
// Headers with zero frame components are dropped in the decode stage.
// Reset (i_rst_n low at a clock edge) empties all stages and sets the limit to 10.
module jpeg_mcu_layout_calc import jml_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    jml_in_if.sink           i_in,
    jml_out_if.source        o_out
);

    // Largest MCU block count the software allows; clamped to the hardware
    // maximum in the sequencer before the compare.
    logic [CFG_W-1:0] r_max_blocks;

    // Decode stage to sequencer.
    logic  dec_valid;
    logic  dec_ready;
    t_hdr  dec_hdr;

    // Sequencer to divider.
    logic  slot_valid;
    logic  slot_ready;
    t_slot slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blocks <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_blocks <= i_cfg_wr_data;
        end
    end

    // Stage 1: factors, their maxima over the frame, and running block counts
    // of the scan entries.
    jml_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_hdr   (dec_hdr)
    );

    // Stages 2 and 3: hold the header, build the MCU id map and limit check,
    // and issue one component per cycle, with its division operands, while the divider accepts.
    jml_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_max_blocks),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_hdr   (dec_hdr),
        .o_valid (slot_valid),
        .i_ready (slot_ready),
        .o_slot  (slot)
    );

    // Stages 4 and 5: reciprocal estimate, correction and block rounding; the
    // last stage is the output register, so a waiting result holds back the
    // stages behind it once they are full.
    jml_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (slot_valid),
        .o_ready (slot_ready),
        .i_slot  (slot),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // A failed limit check needs at least one block in the MCU.
    a_invalid_has_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.layout_valid |-> o_out.blocks_per_mcu != '0)
        else $error("layout flagged invalid with an empty MCU");

    // Anything above the hardware maximum must fail the check.
    a_over_max_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.blocks_per_mcu > NBLK_W'(MCU_BLK_MAX))
        |-> !o_out.layout_valid)
        else $error("oversized MCU passed the limit check");

    // An empty MCU carries an empty id map.
    a_empty_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.blocks_per_mcu == '0) |-> o_out.mcu_origin_map == '0)
        else $error("id map not empty for an MCU without blocks");

    // The highest component index always closes its header.
    a_top_comp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.comp_index == ID_W'(COMP_N - 1)) |-> o_out.last)
        else $error("highest component not marked last");
`endif

endmodule

[src/jml_decode.sv]
`timescale 1ns / 1ps
// Header decode stage: sampling factors, their maxima and MCU block prefix counts.
module jml_decode import jml_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jml_in_if.sink      i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_hdr        o_hdr
);

    logic              r_valid;
    t_hdr              r_hdr;
    t_hdr              n_hdr;
    logic              adv;
    logic [CNT_W-1:0]  nf_sat;
    logic [CNT_W-1:0]  ns_sat;
    logic [ID_W-1:0]   sid;
    logic [NBLK_W-1:0] acc;

    assign adv        = !r_valid || i_ready;
    assign i_in.ready = adv;
    assign o_valid    = r_valid;
    assign o_hdr      = r_hdr;

    always_comb begin
        nf_sat = (i_in.frame_components > CNT_W'(COMP_N)) ? CNT_W'(COMP_N)
                                                           : i_in.frame_components;
        ns_sat = (i_in.scan_components > CNT_W'(SCAN_N)) ? CNT_W'(SCAN_N)
                                                          : i_in.scan_components;
        n_hdr.width  = i_in.image_width;
        n_hdr.height = i_in.image_height;
        n_hdr.nf     = nf_sat;
        n_hdr.single = (i_in.scan_components == CNT_W'(1));
        n_hdr.first  = i_in.first_component;
        n_hdr.ids    = i_in.scan_list;
        for (int k = 0; k < CODE_N; k++) begin
            n_hdr.hf[k] = FAC_W'(i_in.h_factor_codes[ID_W*k +: ID_W]) + FAC_W'(1);
            n_hdr.vf[k] = FAC_W'(i_in.v_factor_codes[ID_W*k +: ID_W]) + FAC_W'(1);
        end
        // Maxima over the frame components only.
        n_hdr.hmax = FAC_W'(1);
        n_hdr.vmax = FAC_W'(1);
        for (int k = 0; k < COMP_N; k++) begin
            if (CNT_W'(k) < nf_sat && n_hdr.hf[k] > n_hdr.hmax) begin
                n_hdr.hmax = n_hdr.hf[k];
            end
            if (CNT_W'(k) < nf_sat && n_hdr.vf[k] > n_hdr.vmax) begin
                n_hdr.vmax = n_hdr.vf[k];
            end
        end
        // Running block count of an interleaved scan, entry by entry.
        acc = '0;
        sid = '0;
        for (int i = 0; i < SCAN_N; i++) begin
            sid = i_in.scan_list[ID_W*i +: ID_W];
            if (CNT_W'(i) < ns_sat && !n_hdr.single) begin
                acc = acc + NBLK_W'(n_hdr.hf[sid]) * NBLK_W'(n_hdr.vf[sid]);
            end
            n_hdr.pfx[i] = acc;
        end
    end

    // Drop headers without frame components.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid && (nf_sat != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

[src/jml_expand.sv]
`timescale 1ns / 1ps
// Component sequencer: holds one header and issues one division slot per component.
module jml_expand import jml_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_limit,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_hdr             i_hdr,
    output logic             o_valid,
    input  logic             i_ready,
    output t_slot            o_slot
);

    logic              r_busy;
    logic [ID_W-1:0]   r_k;
    t_hdr              r_hdr;
    logic [NBLK_W-1:0] r_nblk;
    logic [MAP_W-1:0]  r_map;
    logic              r_ok;
    logic              r_slot_valid;
    t_slot             r_slot;

    t_slot             n_slot;
    logic [NBLK_W-1:0] n_nblk;
    logic [MAP_W-1:0]  n_map;
    logic              n_ok;
    logic [NBLK_W-1:0] lim;
    logic [ID_W-1:0]   bid;
    logic              adv;
    logic              issue;
    logic              last_k;
    logic              load;
    t_fac              hf_k;
    t_fac              vf_k;
    logic [SIZE_W:0]   w_pad;
    logic [SIZE_W:0]   h_pad;

    assign adv     = !r_slot_valid || i_ready;
    assign issue   = r_busy && adv;
    assign last_k  = (r_k == ID_W'(r_hdr.nf - CNT_W'(1)));
    assign o_ready = !r_busy || (adv && last_k);
    assign load    = i_valid && o_ready;
    assign o_valid = r_slot_valid;
    assign o_slot  = r_slot;

    // MCU block count, id map and limit check of the incoming header.
    always_comb begin
        lim = ({{(NBLK_W-CFG_W){1'b0}}, i_limit} > NBLK_W'(MCU_BLK_MAX))
            ? NBLK_W'(MCU_BLK_MAX) : {{(NBLK_W-CFG_W){1'b0}}, i_limit};
        n_map = '0;
        bid   = '0;
        if (i_hdr.single) begin
            n_nblk = NBLK_W'(1);
            n_map  = MAP_W'(i_hdr.first);
        end else begin
            n_nblk = i_hdr.pfx[SCAN_N-1];
            for (int j = 0; j < MAP_REC; j++) begin
                bid = '0;
                for (int i = SCAN_N - 1; i >= 0; i--) begin
                    if (NBLK_W'(j) < i_hdr.pfx[i]) begin
                        bid = i_hdr.ids[i];
                    end
                end
                n_map[ID_W*j +: ID_W] = bid;
            end
        end
        n_ok = (n_nblk <= lim);
    end

    // Numerators and divisors of the four ceiling divisions of component r_k.
    always_comb begin
        hf_k  = r_hdr.hf[r_k];
        vf_k  = r_hdr.vf[r_k];
        w_pad = {1'b0, r_hdr.width} + (SIZE_W+1)'(7);
        h_pad = {1'b0, r_hdr.height} + (SIZE_W+1)'(7);

        n_slot.comp = r_k;
        n_slot.last = last_k;
        n_slot.nblk = r_nblk;
        n_slot.map  = r_map;
        n_slot.ok   = r_ok;

        n_slot.num[LANE_HORIZ] = NUM_W'(r_hdr.width) * NUM_W'(hf_k)
                               + NUM_W'(r_hdr.hmax - FAC_W'(1));
        n_slot.num[LANE_VERT]  = NUM_W'(r_hdr.height) * NUM_W'(vf_k)
                               + NUM_W'(r_hdr.vmax - FAC_W'(1));
        if (r_hdr.single) begin
            n_slot.num[LANE_ROW] = NUM_W'(r_hdr.width) * NUM_W'(r_hdr.hf[r_hdr.first])
                                 + NUM_W'(r_hdr.hmax - FAC_W'(1));
            n_slot.num[LANE_COL] = NUM_W'(r_hdr.height) * NUM_W'(r_hdr.vf[r_hdr.first])
                                 + NUM_W'(r_hdr.vmax - FAC_W'(1));
        end else begin
            n_slot.num[LANE_ROW] = NUM_W'(w_pad[SIZE_W:3]) + NUM_W'(r_hdr.hmax - FAC_W'(1));
            n_slot.num[LANE_COL] = NUM_W'(h_pad[SIZE_W:3]) + NUM_W'(r_hdr.vmax - FAC_W'(1));
        end

        n_slot.den[LANE_HORIZ] = r_hdr.hmax;
        n_slot.den[LANE_VERT]  = r_hdr.vmax;
        n_slot.den[LANE_ROW]   = r_hdr.hmax;
        n_slot.den[LANE_COL]   = r_hdr.vmax;

        n_slot.to_blocks[LANE_HORIZ] = 1'b1;
        n_slot.to_blocks[LANE_VERT]  = 1'b1;
        n_slot.to_blocks[LANE_ROW]   = r_hdr.single;
        n_slot.to_blocks[LANE_COL]   = r_hdr.single;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_k          <= '0;
            r_slot_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (issue && last_k) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_k <= r_k + ID_W'(1);
            end
            if (adv) begin
                r_slot_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hdr  <= i_hdr;
            r_nblk <= n_nblk;
            r_map  <= n_map;
            r_ok   <= n_ok;
        end
        if (issue) begin
            r_slot <= n_slot;
        end
    end

endmodule

[src/jml_divide.sv]
`timescale 1ns / 1ps
// Two-stage floor divider by 1..4 for four lanes, with the result register; the numerators carry the ceiling rounding.
module jml_divide import jml_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_slot       i_slot,
    jml_out_if.source   o_out
);

    typedef struct packed {
        t_slot                         slot;
        logic [LANE_N-1:0][NUM_W-1:0]  q0;
        logic [LANE_N-1:0]             is3;
    } t_stage;

    typedef struct packed {
        logic [ID_W-1:0]               comp;
        logic [LANE_N-1:0][BLK_W-1:0]  val;
        logic [NBLK_W-1:0]             nblk;
        logic [MAP_W-1:0]              map;
        logic                          ok;
        logic                          last;
    } t_res;

    logic                          r1_valid;
    t_stage                        r1;
    t_stage                        n1;
    logic                          r2_valid;
    t_res                          r2;
    t_res                          n2;
    logic [LANE_N-1:0][PROD_W-1:0] prod;
    logic [NUM_W-1:0]              q;
    logic [NUM_W-1:0]              rem;
    logic [NUM_W:0]                q_pad;
    logic                          adv1;
    logic                          adv2;

    assign adv2    = !r2_valid || o_out.ready;
    assign adv1    = !r1_valid || adv2;
    assign o_ready = adv1;

    // Quotient estimate; a divide by three goes through the reciprocal.
    always_comb begin
        n1.slot = i_slot;
        for (int l = 0; l < LANE_N; l++) begin
            prod[l]   = PROD_W'(i_slot.num[l]) * PROD_W'(RECIP3);
            n1.is3[l] = 1'b0;
            case (i_slot.den[l])
                FAC_W'(2): n1.q0[l] = i_slot.num[l] >> 1;
                FAC_W'(3): begin
                    n1.q0[l]  = NUM_W'(prod[l][PROD_W-1:RECIP_SHIFT]);
                    n1.is3[l] = 1'b1;
                end
                FAC_W'(4): n1.q0[l] = i_slot.num[l] >> 2;
                default:   n1.q0[l] = i_slot.num[l];
            endcase
        end
    end

    // Correct a divide-by-three estimate by one, then round lanes marked to_blocks up to whole 8x8 blocks.
    always_comb begin
        n2.comp = r1.slot.comp;
        n2.nblk = r1.slot.nblk;
        n2.map  = r1.slot.map;
        n2.ok   = r1.slot.ok;
        n2.last = r1.slot.last;
        q       = '0;
        rem     = '0;
        q_pad   = '0;
        for (int l = 0; l < LANE_N; l++) begin
            q = r1.q0[l];
            if (r1.is3[l]) begin
                rem = r1.slot.num[l] - ((r1.q0[l] << 1) + r1.q0[l]);
                if (rem >= NUM_W'(3)) begin
                    q = r1.q0[l] + NUM_W'(1);
                end
            end
            q_pad = {1'b0, q} + (NUM_W+1)'(7);
            n2.val[l] = r1.slot.to_blocks[l] ? q_pad[BLK_W+2:3] : q[BLK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r1_valid <= i_valid;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r1 <= n1;
        end
        if (adv2 && r1_valid) begin
            r2 <= n2;
        end
    end

    assign o_out.valid          = r2_valid;
    assign o_out.comp_index     = r2.comp;
    assign o_out.horiz_blocks   = r2.val[LANE_HORIZ];
    assign o_out.vert_blocks    = r2.val[LANE_VERT];
    assign o_out.mcus_per_row   = r2.val[LANE_ROW];
    assign o_out.mcus_per_col   = r2.val[LANE_COL];
    assign o_out.blocks_per_mcu = r2.nblk;
    assign o_out.mcu_origin_map = r2.map;
    assign o_out.layout_valid   = r2.ok;
    assign o_out.last           = r2.last;

endmodule
